FILE: hw/rtl/txpp_pkg.sv
package txpp_pkg;

  // request codes
  localparam int unsigned REQ_W = 2;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

  // event codes
  localparam logic EVT_PACKET = 1'b0;
  localparam logic EVT_FAULT  = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 21;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPP         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CATCHUP = 2'd2;

  // field widths
  localparam int unsigned RATE_W    = 21;
  localparam int unsigned SPP_W     = 11;
  localparam int unsigned MC_W      = 5;
  localparam int unsigned ELAPSED_W = 64;
  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned CNT_W     = 64;

  // reset values of the configuration registers
  localparam logic [RATE_W-1:0] RATE_RST = 21'd192000;
  localparam logic [SPP_W-1:0]  SPP_RST  = 11'd240;
  localparam logic [MC_W-1:0]   MC_RST   = 5'd4;

  // longest catch-up burst
  localparam int unsigned MAX_BURST = 16;
  localparam int unsigned BURST_W   = $clog2(MAX_BURST + 1);

  // scaling datapath
  localparam int unsigned NS_W     = 30;
  localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1_000_000_000;
  localparam int unsigned E_W      = ELAPSED_W - 1;
  localparam int unsigned PROD_W   = E_W + RATE_W;
  localparam int unsigned DIV_W    = NS_W + SPP_W;
  localparam int unsigned SCL_CNT_W = $clog2(PROD_W);

  typedef enum logic [1:0] {
    SCL_IDLE,
    SCL_MUL,
    SCL_DIV
  } scl_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_CHECK,
    ST_DECIDE,
    ST_EXCESS,
    ST_DROP,
    ST_FAULT,
    ST_EMIT
  } pacer_state_e;

  // command to the scaling unit
  typedef struct packed {
    logic              start;
    logic [E_W-1:0]    elapsed;
    logic [RATE_W-1:0] rate;
    logic [DIV_W-1:0]  divisor;
  } scl_cmd_t;

  // answer from the scaling unit
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quotient;
  } scl_rsp_t;

endpackage

FILE: hw/rtl/txpp_if.sv
interface txpp_req_if;
  logic                            valid;
  logic                            ready;
  logic [txpp_pkg::REQ_W-1:0]      req_type;
  logic signed [txpp_pkg::ELAPSED_W-1:0] elapsed_ns;

  modport source (output valid, output req_type, output elapsed_ns, input ready);
  modport sink (input valid, input req_type, input elapsed_ns, output ready);
endinterface

interface txpp_evt_if;
  logic                        valid;
  logic                        ready;
  logic                        event_kind;
  logic [txpp_pkg::SEQ_W-1:0]  sequence_number;
  logic [txpp_pkg::CNT_W-1:0]  dropped_total;
  logic                        last_of_run;

  modport source (output valid, output event_kind, output sequence_number,
                  output dropped_total, output last_of_run, input ready);
  modport sink (input valid, input event_kind, input sequence_number,
                input dropped_total, input last_of_run, output ready);
endinterface

FILE: hw/rtl/txpp_scaler.sv
module txpp_scaler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  txpp_pkg::scl_cmd_t cmd_i,
  output txpp_pkg::scl_rsp_t rsp_o
);
  import txpp_pkg::*;

  scl_state_e             state_q, state_d;
  logic [SCL_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic [E_W-1:0]         elapsed_q, elapsed_d;
  logic [RATE_W-1:0]      rate_q, rate_d;
  logic [DIV_W-1:0]       div_q, div_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [DIV_W-1:0]       rem_q, rem_d;
  logic [CNT_W-1:0]       quo_q, quo_d;
  logic [DIV_W:0]         rem_sh;
  logic [DIV_W:0]         rem_diff;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCL_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    elapsed_q <= elapsed_d;
    rate_q    <= rate_d;
    div_q     <= div_d;
    prod_q    <= prod_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
  end

  // one rate bit per cycle into the product, then one quotient bit per cycle
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    elapsed_d = elapsed_q;
    rate_d    = rate_q;
    div_d     = div_q;
    prod_d    = prod_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    rem_sh    = {rem_q, prod_q[PROD_W-1]};
    rem_diff  = rem_sh - {1'b0, div_q};
    case (state_q)
      SCL_IDLE: begin
        if (cmd_i.start) begin
          elapsed_d = cmd_i.elapsed;
          rate_d    = cmd_i.rate;
          div_d     = cmd_i.divisor;
          prod_d    = '0;
          rem_d     = '0;
          quo_d     = '0;
          cnt_d     = SCL_CNT_W'(RATE_W - 1);
          state_d   = SCL_MUL;
        end
      end
      SCL_MUL: begin
        prod_d = {prod_q[PROD_W-2:0], 1'b0}
               + (rate_q[RATE_W-1] ? PROD_W'(elapsed_q) : '0);
        rate_d = {rate_q[RATE_W-2:0], 1'b0};
        if (cnt_q == '0) begin
          cnt_d   = SCL_CNT_W'(PROD_W - 1);
          state_d = SCL_DIV;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      SCL_DIV: begin
        prod_d = {prod_q[PROD_W-2:0], 1'b0};
        if (rem_sh >= {1'b0, div_q}) begin
          rem_d = rem_diff[DIV_W-1:0];
          quo_d = {quo_q[CNT_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DIV_W-1:0];
          quo_d = {quo_q[CNT_W-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = SCL_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        state_d = SCL_IDLE;
      end
    endcase
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: hw/rtl/tx_packet_pacer_top.sv
// Transmit packet pacer. A start request clears the sequence, scheduled and
// dropped counters, starts the pacer and sends packet 0; a tick request
// carries the nanoseconds elapsed since start and releases one packet event
// for every packet that is due by then, the last one flagged with
// last_of_run. If more packets are due than max_catchup (at most 16), the
// excess is added to the dropped count, one fault event is sent and the
// pacer stops. A stop request, a tick while stopped and a tick with negative
// time produce nothing. One request is handled at a time: a start or a
// running tick runs a bit-serial multiply and then a bit-serial divide in the
// scaling unit, plus decision steps, then releases its events one per cycle
// while the consumer keeps up; a stop or ignored request is handled in the
// idle state. The configuration registers (0 sample_rate,
// 1 samples_per_packet, 2 max_catchup) are to be written through cfg_we_i only
// while no request is in progress; the block itself does not enforce this.
module tx_packet_pacer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [txpp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [txpp_pkg::CFG_W-1:0]       cfg_data_i,
  txpp_req_if.sink                         req_i,
  txpp_evt_if.source                       evt_o
);
  import txpp_pkg::*;

  pacer_state_e        state_q, state_d;
  logic                running_q, running_d;
  logic [SEQ_W-1:0]    seq_q, seq_d;
  logic [CNT_W-1:0]    sched_q, sched_d;
  logic [CNT_W-1:0]    dropped_q, dropped_d;
  logic [CNT_W-1:0]    target_q, target_d;
  logic [CNT_W-1:0]    due_q, due_d;
  logic [BURST_W-1:0]  left_q, left_d;

  logic [RATE_W-1:0]   rate_q;
  logic [SPP_W-1:0]    spp_q;
  logic [MC_W-1:0]     mc_q;

  logic                out_valid_q, out_valid_d;
  logic                out_kind_q, out_kind_d;
  logic [SEQ_W-1:0]    out_seq_q, out_seq_d;
  logic [CNT_W-1:0]    out_drop_q, out_drop_d;
  logic                out_last_q, out_last_d;
  logic                out_load;

  scl_cmd_t            scl_cmd;
  scl_rsp_t            scl_rsp;
  logic [SPP_W-1:0]    spp_eff;
  logic [BURST_W-1:0]  cap;
  logic [CNT_W:0]      diff;
  logic                slot_free;
  logic                req_fire;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RST;
      spp_q  <= SPP_RST;
      mc_q   <= MC_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SAMPLE_RATE: rate_q <= cfg_data_i[RATE_W-1:0];
        CFG_SPP:         spp_q  <= cfg_data_i[SPP_W-1:0];
        CFG_MAX_CATCHUP: mc_q   <= cfg_data_i[MC_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      running_q   <= 1'b0;
      seq_q       <= '0;
      sched_q     <= '0;
      dropped_q   <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      seq_q       <= seq_d;
      sched_q     <= sched_d;
      dropped_q   <= dropped_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    target_q   <= target_d;
    due_q      <= due_d;
    out_kind_q <= out_kind_d;
    out_seq_q  <= out_seq_d;
    out_drop_q <= out_drop_d;
    out_last_q <= out_last_d;
  end

  // effective packet size and burst limit
  always_comb begin
    spp_eff = (spp_q == '0) ? SPP_W'(1) : spp_q;
    if (32'(mc_q) > MAX_BURST) begin
      cap = BURST_W'(MAX_BURST);
    end else begin
      cap = BURST_W'(mc_q);
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign slot_free   = !out_valid_q || evt_o.ready;
  assign diff        = {1'b0, target_q} - {1'b0, sched_q};

  // sequencer: start scaling, check the target, then emit packet events or one fault event
  always_comb begin
    state_d    = state_q;
    running_d  = running_q;
    seq_d      = seq_q;
    sched_d    = sched_q;
    dropped_d  = dropped_q;
    target_d   = target_q;
    due_d      = due_q;
    left_d     = left_q;
    out_load   = 1'b0;
    out_kind_d = out_kind_q;
    out_seq_d  = out_seq_q;
    out_drop_d = out_drop_q;
    out_last_d = out_last_q;

    scl_cmd.start   = 1'b0;
    scl_cmd.elapsed = req_i.elapsed_ns[E_W-1:0];
    scl_cmd.rate    = rate_q;
    scl_cmd.divisor = DIV_W'(NS_PER_SEC) * DIV_W'(spp_eff);

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          case (req_i.req_type)
            REQ_TICK: begin
              if (running_q && !req_i.elapsed_ns[ELAPSED_W-1]) begin
                scl_cmd.start = 1'b1;
                state_d       = ST_CALC;
              end
            end
            REQ_START: begin
              running_d       = 1'b1;
              seq_d           = '0;
              sched_d         = '0;
              dropped_d       = '0;
              scl_cmd.elapsed = '0;
              scl_cmd.start   = 1'b1;
              state_d         = ST_CALC;
            end
            REQ_STOP: begin
              running_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_CALC: begin
        if (scl_rsp.done) begin
          target_d = scl_rsp.quotient + 1'b1;
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // nothing due unless the target lies ahead of the schedule
        if (diff[CNT_W] || diff[CNT_W-1:0] == '0) begin
          state_d = ST_IDLE;
        end else begin
          due_d   = diff[CNT_W-1:0];
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (due_q > CNT_W'(cap)) begin
          state_d = ST_EXCESS;
        end else begin
          left_d  = due_q[BURST_W-1:0];
          state_d = ST_EMIT;
        end
      end
      ST_EXCESS: begin
        due_d   = due_q - CNT_W'(cap);
        state_d = ST_DROP;
      end
      ST_DROP: begin
        dropped_d = dropped_q + due_q;
        running_d = 1'b0;
        state_d   = ST_FAULT;
      end
      ST_FAULT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_kind_d = EVT_FAULT;
          out_seq_d  = seq_q;
          out_drop_d = dropped_q;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_kind_d = EVT_PACKET;
          out_seq_d  = seq_q;
          out_drop_d = dropped_q;
          out_last_d = (left_q == BURST_W'(1));
          seq_d      = seq_q + 1'b1;
          sched_d    = sched_q + 1'b1;
          left_d     = left_q - 1'b1;
          if (left_q == BURST_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // output register holds one transaction until taken
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (evt_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  txpp_scaler u_scaler (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (scl_cmd),
    .rsp_o  (scl_rsp)
  );

  assign evt_o.valid           = out_valid_q;
  assign evt_o.event_kind      = out_kind_q;
  assign evt_o.sequence_number = out_seq_q;
  assign evt_o.dropped_total   = out_drop_q;
  assign evt_o.last_of_run     = out_last_q;

endmodule
